### rtl/xrrg_pkg.sv
// Package for the xorshift random range generator.
// Holds widths, the seed reset value and the xorshift step function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package xrrg_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned CountW = 5;
  localparam logic [DataW-1:0] SEED_RESET = 32'd2463534242;
  localparam int unsigned SHIFT_A = 13;
  localparam int unsigned SHIFT_B = 17;
  localparam int unsigned SHIFT_C = 5;

  function automatic logic [DataW-1:0] xorshift_next(input logic [DataW-1:0] x);
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
    a = x ^ (x << SHIFT_A);
    b = a ^ (a >> SHIFT_B);
    return b ^ (b << SHIFT_C);
  endfunction

endpackage

`default_nettype wire

### rtl/xrrg_channels.sv
// Valid/ready channel interfaces for requests and results.
// Depends on xrrg_pkg for the data width.
`timescale 1ns / 1ps
`default_nettype none

interface xrrg_req_if
  import xrrg_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             bounded;
  logic [DataW-1:0] range_low;
  logic [DataW-1:0] range_high;
  modport source (output valid, output bounded, output range_low, output range_high,
                  input ready);
  modport sink (input valid, input bounded, input range_low, input range_high,
                output ready);
endinterface

interface xrrg_rsp_if
  import xrrg_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [DataW-1:0] random_value;
  modport source (output valid, output random_value, input ready);
  modport sink (input valid, input random_value, output ready);
endinterface

`default_nettype wire

### rtl/xrrg_remainder.sv
// Iterative restoring remainder unit, one dividend bit per cycle.
// Depends on xrrg_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module xrrg_remainder
  import xrrg_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DataW-1:0] dividend,
  input  wire logic [DataW-1:0] divisor,
  output logic                  done,
  output logic [DataW-1:0]      remainder
);

  logic             busy;
  logic [CountW-1:0] count;
  logic [DataW-1:0] dvd;
  logic [DataW-1:0] dvs;
  logic [DataW-1:0] rem;
  logic [DataW:0]   shifted;
  logic [DataW:0]   trial;
  logic [DataW-1:0] rem_next;

  always_comb begin
    shifted = {rem, dvd[DataW-1]};
    trial = shifted - {1'b0, dvs};
    if (trial[DataW]) begin
      rem_next = shifted[DataW-1:0];
    end else begin
      rem_next = trial[DataW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= '1;
        dvd <= dividend;
        dvs <= divisor;
        rem <= '0;
      end else if (busy) begin
        rem <= rem_next;
        dvd <= {dvd[DataW-2:0], 1'b0};
        count <= count - 1'b1;
        if (count == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign remainder = rem;

endmodule

`default_nettype wire

### rtl/xorshift_random_range_generator_top.sv
// Top level of the xorshift random range generator.
// Depends on xrrg_pkg, the channel interfaces and xrrg_remainder.
//
// Each request on req carries bounded, range_low and range_high and gives
// one result on rsp. A raw request, or a bounded request with an empty
// range, is answered in the cycle after it is taken. A bounded request with
// a nonempty range advances the generator and reduces the value through a
// remainder unit that resolves one bit per cycle; its result goes to the
// output register once the unit signals done. The block takes one
// request at a time; req.ready is high when the sequencer is idle and the
// output register is empty or being emptied in the same cycle.
// Raw and empty-range requests can be taken on every cycle while the
// receiver keeps up; none is taken while a bounded one is being reduced.
// A stalled receiver holds the result in the output register and blocks
// further requests until it is taken.
// Reset empties the output register and loads the generator state with
// 2463534242. A write on cfg_wr_en with nonzero data reloads the state;
// zero is ignored. Users write only while idle; the block won't check.
`timescale 1ns / 1ps
`default_nettype none

module xorshift_random_range_generator_top
  import xrrg_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_wr_en,
  input  wire logic [DataW-1:0] cfg_wr_data,
  xrrg_req_if.sink              req,
  xrrg_rsp_if.source            rsp
);

  typedef enum logic {
    ST_IDLE,
    ST_REDUCE
  } seq_state_t;

  seq_state_t       state;
  logic [DataW-1:0] gen_state;
  logic [DataW-1:0] gen_next;
  logic [DataW-1:0] low_q;
  logic [DataW-1:0] out_data;
  logic             out_valid;
  logic             accept;
  logic             empty_range;
  logic             rem_start;
  logic             rem_done;
  logic [DataW-1:0] rem_value;

  assign gen_next = xorshift_next(gen_state);
  assign req.ready = (state == ST_IDLE) && (!out_valid || rsp.ready);
  assign accept = req.valid && req.ready;
  assign empty_range = req.range_high <= req.range_low;
  assign rem_start = accept && req.bounded && !empty_range;

  xrrg_remainder u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (rem_start),
    .dividend  (gen_next),
    .divisor   (req.range_high - req.range_low),
    .done      (rem_done),
    .remainder (rem_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      gen_state <= SEED_RESET;
    end else begin
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_wr_en && (cfg_wr_data != '0)) begin
        gen_state <= cfg_wr_data;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            low_q <= req.range_low;
            if (!req.bounded) begin
              gen_state <= gen_next;
              out_data <= gen_next;
              out_valid <= 1'b1;
            end else if (empty_range) begin
              out_data <= req.range_low;
              out_valid <= 1'b1;
            end else begin
              gen_state <= gen_next;
              state <= ST_REDUCE;
            end
          end
        end
        ST_REDUCE: begin
          if (rem_done) begin
            out_data <= low_q + rem_value;
            out_valid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.random_value = out_data;

endmodule

`default_nettype wire

### sim/xrrg_result_checker.sv
// Checker for the xorshift random range generator: watches the request, result
// and seed-write ports, predicts each result and compares it in order.
// Depends on xrrg_pkg for the data width and the seed reset value.
`timescale 1ns / 1ps

module xrrg_result_checker
  import xrrg_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [DataW-1:0] cfg_wr_data,
  input  logic             req_valid,
  input  logic             req_ready,
  input  logic             req_bounded,
  input  logic [DataW-1:0] req_low,
  input  logic [DataW-1:0] req_high,
  input  logic             rsp_valid,
  input  logic             rsp_ready,
  input  logic [DataW-1:0] rsp_value,
  output int               mismatch_count,
  output int               pending_count
);

  logic [DataW-1:0] gen_state;
  logic [DataW-1:0] expected_values[$];

  function automatic logic [DataW-1:0] xorshift_advance(input logic [DataW-1:0] x);
    logic [DataW-1:0] t;
    t = x ^ {x[18:0], 13'b0};
    t = t ^ {17'b0, t[31:17]};
    return t ^ {t[26:0], 5'b0};
  endfunction

  task automatic report_mismatch(input logic [DataW-1:0] exp_value, input bit have_exp);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      if (have_exp) begin
        $display("mismatch: random_value expected %h actual %h", exp_value, rsp_value);
      end else begin
        $display("mismatch: result %h arrived with no request outstanding", rsp_value);
      end
    end
  endtask

  always @(posedge clk) begin
    logic [DataW-1:0] exp_value;
    if (rst) begin
      gen_state = SEED_RESET;
      expected_values.delete();
      pending_count <= 0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_wr_data != '0) begin
          gen_state = cfg_wr_data;
        end
      end
      if (req_valid && req_ready) begin
        if (!req_bounded) begin
          gen_state = xorshift_advance(gen_state);
          expected_values.push_back(gen_state);
        end else if (req_high <= req_low) begin
          expected_values.push_back(req_low);
        end else begin
          gen_state = xorshift_advance(gen_state);
          expected_values.push_back(req_low + gen_state % (req_high - req_low));
        end
      end
      if (rsp_valid && rsp_ready) begin
        if (expected_values.size() == 0) begin
          report_mismatch('0, 1'b0);
        end else begin
          exp_value = expected_values.pop_front();
          if (exp_value !== rsp_value) begin
            report_mismatch(exp_value, 1'b1);
          end
        end
      end
      pending_count <= expected_values.size();
    end
  end

endmodule

### sim/tb.sv
// Testbench top for the xorshift random range generator: clock, reset,
// request and seed-write stimulus, receiver back-pressure and the verdict.
// Depends on xrrg_pkg, the channel interfaces, the block and xrrg_result_checker.
`timescale 1ns / 1ps

module tb
  import xrrg_pkg::*;
();

  localparam int LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [DataW-1:0] MAX_VALUE = 32'hFFFF_FFFF;

  logic             clk;
  logic             rst;
  logic             cfg_wr_en;
  logic [DataW-1:0] cfg_wr_data;
  int               mismatch_count;
  int               pending_count;
  int               cycles;
  bit               idle_on;
  bit               stall_request;

  xrrg_req_if req_ch();
  xrrg_rsp_if rsp_ch();

  xorshift_random_range_generator_top dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .req        (req_ch),
    .rsp        (rsp_ch)
  );

  xrrg_result_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .req_valid     (req_ch.valid),
    .req_ready     (req_ch.ready),
    .req_bounded   (req_ch.bounded),
    .req_low       (req_ch.range_low),
    .req_high      (req_ch.range_high),
    .rsp_valid     (rsp_ch.valid),
    .rsp_ready     (rsp_ch.ready),
    .rsp_value     (rsp_ch.random_value),
    .mismatch_count(mismatch_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("xorshift_random_range_generator_top verification failed");
    $finish;
  end

  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        rsp_ch.ready <= !(idle_on && $urandom_range(99) < 8);
      end
    end
  end

  task automatic send_request(input logic b, input logic [DataW-1:0] lo,
                              input logic [DataW-1:0] hi);
    while (idle_on && $urandom_range(99) < 8) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.bounded    <= b;
    req_ch.range_low  <= lo;
    req_ch.range_high <= hi;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    repeat (3) @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_seed(input logic [DataW-1:0] value);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [DataW-1:0] corner_value();
    case ($urandom_range(6))
      0: return '0;
      1: return 32'd1;
      2: return 32'h7FFF_FFFF;
      3: return 32'h8000_0000;
      4: return 32'hFFFF_FFFE;
      5: return MAX_VALUE;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_request();
    int               kind;
    logic [DataW-1:0] lo;
    logic [DataW-1:0] hi;
    logic [DataW-1:0] swap;
    kind = $urandom_range(99);
    lo = $urandom;
    hi = $urandom;
    if (kind < 35) begin
      send_request(1'b0, lo, hi);
    end else if (kind < 48) begin
      if (hi > lo) begin
        swap = hi;
        hi = lo;
        lo = swap;
      end
      if ($urandom_range(3) == 0) hi = lo;
      send_request(1'b1, lo, hi);
    end else if (kind < 75) begin
      hi = lo + $urandom_range(64, 1);
      send_request(1'b1, lo, hi);
    end else if (kind < 90) begin
      send_request(1'b1, lo, hi);
    end else begin
      send_request(1'b1, corner_value(), corner_value());
    end
  endtask

  initial begin
    logic [DataW-1:0] seeds[6];
    rst               <= 1'b1;
    cfg_wr_en         <= 1'b0;
    cfg_wr_data       <= '0;
    req_ch.valid      <= 1'b0;
    req_ch.bounded    <= 1'b0;
    req_ch.range_low  <= '0;
    req_ch.range_high <= '0;
    idle_on       = 1'b1;
    stall_request = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(1'b0, '0, '0);
    send_request(1'b0, MAX_VALUE, MAX_VALUE);
    send_request(1'b1, '0, MAX_VALUE);
    send_request(1'b1, 32'hFFFF_FFFE, MAX_VALUE);
    send_request(1'b1, 32'd5, 32'd5);
    send_request(1'b1, MAX_VALUE, '0);
    send_request(1'b1, '0, 32'd1);
    send_request(1'b1, 32'h8000_0000, MAX_VALUE);
    send_request(1'b1, '0, 32'h8000_0000);
    send_request(1'b1, 32'd100, 32'd107);
    send_request(1'b0, 32'hAAAA_AAAA, 32'h5555_5555);
    send_request(1'b1, 32'h5555_5555, 32'hAAAA_AAAA);
    send_request(1'b1, MAX_VALUE, MAX_VALUE);
    send_request(1'b1, '0, '0);
    write_seed('0);
    send_request(1'b0, '0, '0);
    send_request(1'b1, 32'd10, 32'd1000);
    write_seed(32'd1);
    send_request(1'b0, MAX_VALUE, '0);
    send_request(1'b0, '0, MAX_VALUE);
    send_request(1'b1, '0, MAX_VALUE);
    write_seed(MAX_VALUE);
    send_request(1'b0, '0, '0);

    seeds[0] = $urandom | 32'd1;
    seeds[1] = 32'h8000_0000;
    seeds[2] = '0;
    seeds[3] = $urandom;
    seeds[4] = 32'd1;
    seeds[5] = $urandom;
    for (int phase = 0; phase < 6; phase++) begin
      write_seed(seeds[phase]);
      idle_on = (phase != 2);
      for (int n = 0; n < 100; n++) begin
        if (phase == 4 && n == 40) stall_request = 1'b1;
        random_request();
      end
    end
    idle_on = 1'b1;

    wait_drained();
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("xorshift_random_range_generator_top verification clean");
    end else begin
      $display("xorshift_random_range_generator_top verification failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/xrrg_pkg.sv
rtl/xrrg_channels.sv
rtl/xrrg_remainder.sv
rtl/xorshift_random_range_generator_top.sv
sim/xrrg_result_checker.sv
sim/tb.sv
